// ----- design/lss_pkg.sv -----
package lss_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

   // Fixed field widths of the channels.
   localparam int WORD_W   = 32;
   localparam int OPCODE_W = 2;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_SORT = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Source of the memory read address.
   typedef enum logic [1:0] {
      RD_TOP = 2'd0,
      RD_I   = 2'd1,
      RD_JM1 = 2'd2,
      RD_JM2 = 2'd3
   } rd_sel_type;

   // Source of the memory write address and data.
   typedef enum logic [1:0] {
      WR_PUSH  = 2'd0,
      WR_SHIFT = 2'd1,
      WR_KEY   = 2'd2
   } wr_sel_type;

   typedef struct packed {
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       i_init;
      logic       i_inc;
      logic       j_load;
      logic       j_dec;
      logic       key_load;
      logic       rsp_load;
      logic       rsp_use_rd;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic few;      // fewer than two words stored
      logic key_gt;   // key word is greater than the word just read
      logic j_one;    // insertion point has reached the second entry
      logic i_last;   // current key is the topmost word
      logic rsp_busy; // result register holds a beat that is not being taken
   } sts_type;

endpackage

// ----- design/lifo_stack_with_sort.sv -----
// Bounded LIFO stack of signed 32-bit words with an in-place sort command.
// The request channel (req_valid, req_stall, req_opcode, req_push_value)
// carries one command per beat: push, pop, peek or sort. The response
// channel (rsp_valid, rsp_stall, rsp_*) returns exactly one beat for every
// command, in order: the word read, the fill level, an empty flag and a status.
// Push, and any command that fails on an empty or full stack, has its
// response registered at the edge that takes the request, so it appears one
// cycle later and the next request may be taken in that same cycle. Pop and
// peek read the word memory through its registered read port and load the
// response in S_READ. Sort is an insertion sort run by the controller over
// the word memory: each key is read in S_KEY_RD, captured in S_KEY_CAP,
// compared and shifted past every smaller word below it in S_CMP, and written
// into place in S_PLACE; req_stall stays high for the whole walk. A request
// is taken only while the result register is empty or being drained, so a
// stalled response holds its beat and simply stalls the request side in turn.
// Synchronous reset empties the stack and drops any pending response; the
// memory contents are not cleared.
module lifo_stack_with_sort (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [lss_pkg::OPCODE_W-1:0] req_opcode,
   input  logic signed [lss_pkg::WORD_W-1:0]   req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lss_pkg::WORD_W-1:0]   rsp_read_value,
   output logic        [lss_pkg::FILL_W-1:0]   rsp_fill_level,
   output logic                                rsp_is_empty,
   output logic        [lss_pkg::STATUS_W-1:0] rsp_status
);
   import lss_pkg::*;

   // Commands from the controller to the datapath, and status back.
   cmd_type cmd;
   sts_type sts;

   // The controller owns sequencing: command decode and the sort walk.
   lss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the word memory, the fill count, the sort indices
   // and the response register.
   lss_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_push_value (req_push_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_fill_level (rsp_fill_level),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_status     (rsp_status)
   );

   // A response is never loaded over a beat that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid && rsp_stall))
      else $error("response register overwritten while stalled");

   // The fill count never moves both ways at once.
   a_count_one_way: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_inc && cmd.cnt_dec))
      else $error("fill count incremented and decremented together");

   // A pop or peek on a non-empty stack holds off the next request for its read.
   a_read_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !sts.empty &&
       (req_opcode == OP_POP || req_opcode == OP_PEEK)) |=> req_stall)
      else $error("request taken during a memory read");

   // Memory writes only happen during a push or the sort walk; this check covers pops.
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !cmd.cnt_dec)
      else $error("memory written during a pop");

endmodule

// ----- design/lss_ctrl.sv -----
module lss_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [lss_pkg::OPCODE_W-1:0]  req_opcode,
   output logic                          req_stall,
   input  lss_pkg::sts_type              sts,
   output lss_pkg::cmd_type              cmd
);
   import lss_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_READ    = 6'b000010,
      S_KEY_RD  = 6'b000100,
      S_KEY_CAP = 6'b001000,
      S_CMP     = 6'b010000,
      S_PLACE   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = !((state_ff == S_IDLE) && !sts.rsp_busy);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_TOP;
      cmd.wr_sel     = WR_PUSH;
      cmd.rsp_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_opcode))
                  OP_PUSH: begin
                     cmd.rsp_load = 1'b1;
                     if (sts.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.cnt_inc = 1'b1;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (sts.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.cnt_dec = (op_type'(req_opcode) == OP_POP);
                        state_in    = S_READ;
                     end
                  end
                  OP_SORT: begin
                     cmd.i_init = 1'b1;
                     if (sts.few) begin
                        cmd.rsp_load = 1'b1;
                     end else begin
                        state_in = S_KEY_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_use_rd = 1'b1;
            state_in       = S_IDLE;
         end
         S_KEY_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_I;
            cmd.j_load = 1'b1;
            state_in   = S_KEY_CAP;
         end
         S_KEY_CAP: begin
            cmd.key_load = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_JM1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            if (sts.key_gt) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SHIFT;
               cmd.j_dec  = 1'b1;
               if (sts.j_one) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_JM2;
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_KEY;
            cmd.i_inc  = 1'b1;
            if (sts.i_last) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_KEY_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/lss_dpath.sv -----
module lss_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [lss_pkg::WORD_W-1:0]   req_push_value,
   input  lss_pkg::cmd_type                    cmd,
   output lss_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lss_pkg::WORD_W-1:0]   rsp_read_value,
   output logic        [lss_pkg::FILL_W-1:0]   rsp_fill_level,
   output logic                                rsp_is_empty,
   output logic        [lss_pkg::STATUS_W-1:0] rsp_status
);
   import lss_pkg::*;

   logic [WORD_W-1:0]   word_store_ff [STACK_DEPTH];
   logic [WORD_W-1:0]   rd_data_ff;
   logic [WORD_W-1:0]   key_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic [ADDR_W-1:0]   i_ff;
   logic [ADDR_W-1:0]   i_in;
   logic [ADDR_W-1:0]   j_ff;
   logic [ADDR_W-1:0]   j_in;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [WORD_W-1:0]   rsp_read_value_ff;
   logic [FILL_W-1:0]   rsp_fill_level_ff;
   logic                rsp_is_empty_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_TOP:  rd_addr = ADDR_W'(count_ff - 1'b1);
         RD_I:    rd_addr = i_ff;
         RD_JM1:  rd_addr = j_ff - 1'b1;
         RD_JM2:  rd_addr = j_ff - 2'd2;
         default: rd_addr = i_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_PUSH: begin
            wr_addr = ADDR_W'(count_ff);
            wr_data = req_push_value;
         end
         WR_SHIFT: begin
            wr_addr = j_ff;
            wr_data = rd_data_ff;
         end
         WR_KEY: begin
            wr_addr = j_ff;
            wr_data = key_ff;
         end
         default: begin
            wr_addr = j_ff;
            wr_data = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         word_store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= word_store_ff[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      i_in = i_ff;
      if (cmd.i_init) begin
         i_in = ADDR_W'(1);
      end else if (cmd.i_inc) begin
         i_in = i_ff + 1'b1;
      end
      j_in = j_ff;
      if (cmd.j_load) begin
         j_in = i_ff;
      end else if (cmd.j_dec) begin
         j_in = j_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      if (cmd.key_load) begin
         key_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_read_value_ff <= cmd.rsp_use_rd ? rd_data_ff : '0;
         rsp_fill_level_ff <= FILL_W'(count_in);
         rsp_is_empty_ff   <= (count_in == '0);
         rsp_status_ff     <= cmd.rsp_status;
      end
   end

   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == COUNT_W'(STACK_DEPTH));
   assign sts.few      = (count_ff < COUNT_W'(2));
   assign sts.key_gt   = ($signed(key_ff) > $signed(rd_data_ff));
   assign sts.j_one    = (j_ff == ADDR_W'(1));
   assign sts.i_last   = ((COUNT_W'(i_ff) + 1'b1) >= count_ff);
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_fill_level = rsp_fill_level_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
